// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/es2c_pkg.sv -----
// ----------------------------------------------------------------------------
// es2c_pkg
// Constants, control word layout and microprogram for the epoch converter.
// ----------------------------------------------------------------------------
package es2c_pkg;

   localparam int unsigned EPOCH_W = 32;
   localparam int unsigned REM_W   = 32;
   localparam int unsigned DAYS_W  = 16;   // max day count 49710
   localparam int unsigned DIV_W   = 17;   // widest divisor, 86400
   localparam int unsigned STEP_W  = 4;
   localparam int unsigned MUL_A_W = 25;   // multiplier operand
   localparam int unsigned MUL_M_W = 26;   // reciprocal constant
   localparam int unsigned PROD_W  = MUL_A_W + MUL_M_W;

   localparam logic [DIV_W-1:0] DAY_SECS  = 17'd86400;
   localparam logic [DIV_W-1:0] HOUR_SECS = 17'd3600;
   localparam logic [DIV_W-1:0] MIN_SECS  = 17'd60;

   // q = (x * RECIP) >> SHIFT, exact over each operand's range.
   // Days use (t >> 7) / 675, since 86400 = 128 * 675.
   localparam logic [MUL_M_W-1:0] DAY_RECIP  = 26'd50903317;
   localparam logic [MUL_M_W-1:0] HOUR_RECIP = 26'd149131;
   localparam logic [MUL_M_W-1:0] MIN_RECIP  = 26'd4370;
   localparam int unsigned DAY_SHIFT  = 35;
   localparam int unsigned HOUR_SHIFT = 29;
   localparam int unsigned MIN_SHIFT  = 18;

   localparam logic [7:0] FIRST_YEAR = 8'd70;
   localparam logic [3:0] LAST_MONTH = 4'd11;

   // micro-ops
   localparam logic [2:0] OP_IDLE  = 3'd0;
   localparam logic [2:0] OP_QUO   = 3'd1;
   localparam logic [2:0] OP_REM   = 3'd2;
   localparam logic [2:0] OP_YEAR  = 3'd3;
   localparam logic [2:0] OP_MONTH = 3'd4;
   localparam logic [2:0] OP_OUT   = 3'd5;

   // divisor select
   localparam logic [1:0] DSEL_DAY  = 2'd0;
   localparam logic [1:0] DSEL_HOUR = 2'd1;
   localparam logic [1:0] DSEL_MIN  = 2'd2;

   // quotient destination
   localparam logic [1:0] DST_NONE = 2'd0;
   localparam logic [1:0] DST_DAYS = 2'd1;
   localparam logic [1:0] DST_HOUR = 2'd2;
   localparam logic [1:0] DST_MIN  = 2'd3;

   // program steps
   localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DAY_Q  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DAY_R  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_HOUR_Q = 4'd3;
   localparam logic [STEP_W-1:0] STEP_HOUR_R = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MIN_Q  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_MIN_R  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_YEAR   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_MONTH  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_OUT    = 4'd9;

   typedef struct packed {
      logic [2:0]        op;
      logic [1:0]        dsel;
      logic [1:0]        dst;
      logic [STEP_W-1:0] next;    // step taken when this one finishes
   } ctrl_word_type;

   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      case (step)
         STEP_IDLE:   cw = '{OP_IDLE,  DSEL_DAY,  DST_NONE, STEP_DAY_Q};
         STEP_DAY_Q:  cw = '{OP_QUO,   DSEL_DAY,  DST_NONE, STEP_DAY_R};
         STEP_DAY_R:  cw = '{OP_REM,   DSEL_DAY,  DST_DAYS, STEP_HOUR_Q};
         STEP_HOUR_Q: cw = '{OP_QUO,   DSEL_HOUR, DST_NONE, STEP_HOUR_R};
         STEP_HOUR_R: cw = '{OP_REM,   DSEL_HOUR, DST_HOUR, STEP_MIN_Q};
         STEP_MIN_Q:  cw = '{OP_QUO,   DSEL_MIN,  DST_NONE, STEP_MIN_R};
         STEP_MIN_R:  cw = '{OP_REM,   DSEL_MIN,  DST_MIN,  STEP_YEAR};
         STEP_YEAR:   cw = '{OP_YEAR,  DSEL_DAY,  DST_NONE, STEP_MONTH};
         STEP_MONTH:  cw = '{OP_MONTH, DSEL_DAY,  DST_NONE, STEP_OUT};
         STEP_OUT:    cw = '{OP_OUT,   DSEL_DAY,  DST_NONE, STEP_IDLE};
         default:     cw = '{OP_IDLE,  DSEL_DAY,  DST_NONE, STEP_DAY_Q};
      endcase
      return cw;
   endfunction

   function automatic logic [DIV_W-1:0] divisor(input logic [1:0] dsel);
      logic [DIV_W-1:0] d;
      case (dsel)
         DSEL_DAY:  d = DAY_SECS;
         DSEL_HOUR: d = HOUR_SECS;
         DSEL_MIN:  d = MIN_SECS;
         default:   d = DAY_SECS;
      endcase
      return d;
   endfunction

   function automatic logic [MUL_M_W-1:0] recip(input logic [1:0] dsel);
      logic [MUL_M_W-1:0] m;
      case (dsel)
         DSEL_DAY:  m = DAY_RECIP;
         DSEL_HOUR: m = HOUR_RECIP;
         DSEL_MIN:  m = MIN_RECIP;
         default:   m = DAY_RECIP;
      endcase
      return m;
   endfunction

   function automatic logic [4:0] days_in_month(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      case (mon)
         4'd0:    len = 5'd31;
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         4'd11:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ----- hdl/epoch_seconds_to_calendar.sv -----
// From request to result: six divide steps, then the year loop (one year
// per cycle) and the month loop.
// One request at a time; a new one is taken while the last result still
// waits on rsp_ready.
// Reset: synchronous, active high; clears the step counter and rsp_valid.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Microcoded converter from 32-bit epoch seconds to calendar fields.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [es2c_pkg::EPOCH_W-1:0]  req_epoch_seconds,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [5:0]                    rsp_second,
   output logic [5:0]                    rsp_minute,
   output logic [4:0]                    rsp_hour,
   output logic [4:0]                    rsp_day_of_month,
   output logic [3:0]                    rsp_month,
   output logic [7:0]                    rsp_year_since_1900
);

   es2c_pkg::ctrl_word_type cw;

   logic [es2c_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [es2c_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [es2c_pkg::DAYS_W-1:0]   q_ff, q_in;
   logic [es2c_pkg::DAYS_W-1:0]   days_ff, days_in;
   logic [7:0]                    year_ff, year_in;
   logic [3:0]                    mon_ff, mon_in;
   logic [4:0]                    hour_ff, hour_in;
   logic [5:0]                    minute_ff, minute_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_second_ff, rsp_second_in;
   logic [5:0]  rsp_minute_ff, rsp_minute_in;
   logic [4:0]  rsp_hour_ff, rsp_hour_in;
   logic [4:0]  rsp_day_ff, rsp_day_in;
   logic [3:0]  rsp_month_ff, rsp_month_in;
   logic [7:0]  rsp_year_ff, rsp_year_in;

   logic [es2c_pkg::MUL_A_W-1:0] mul_a;
   logic [es2c_pkg::PROD_W-1:0]  prod;
   logic [es2c_pkg::DAYS_W-1:0]  quo;
   logic [es2c_pkg::REM_W-1:0]   back;
   logic                         leap;
   logic [8:0]                   ylen;
   logic [4:0]                   mlen;

   always_comb begin
      cw = es2c_pkg::ucode(step_ff);
      // quotient by reciprocal multiply; operand is the running remainder
      case (cw.dsel)
         es2c_pkg::DSEL_HOUR: mul_a = {{(es2c_pkg::MUL_A_W-17){1'b0}}, rem_ff[16:0]};
         es2c_pkg::DSEL_MIN:  mul_a = {{(es2c_pkg::MUL_A_W-12){1'b0}}, rem_ff[11:0]};
         default:             mul_a = rem_ff[es2c_pkg::REM_W-1:7];
      endcase
      prod = {{es2c_pkg::MUL_M_W{1'b0}}, mul_a} *
             {{es2c_pkg::MUL_A_W{1'b0}}, es2c_pkg::recip(cw.dsel)};
      case (cw.dsel)
         es2c_pkg::DSEL_HOUR:
            quo = {{(es2c_pkg::DAYS_W-5){1'b0}}, prod[es2c_pkg::HOUR_SHIFT +: 5]};
         es2c_pkg::DSEL_MIN:
            quo = {{(es2c_pkg::DAYS_W-6){1'b0}}, prod[es2c_pkg::MIN_SHIFT +: 6]};
         default:
            quo = prod[es2c_pkg::DAY_SHIFT +: es2c_pkg::DAYS_W];
      endcase
      back = {{(es2c_pkg::REM_W-es2c_pkg::DAYS_W){1'b0}}, q_ff} *
             {{(es2c_pkg::REM_W-es2c_pkg::DIV_W){1'b0}}, es2c_pkg::divisor(cw.dsel)};
      leap = (year_ff[1:0] == 2'b00);
      ylen = leap ? 9'd366 : 9'd365;
      mlen = es2c_pkg::days_in_month(mon_ff, leap);
   end

   always_comb begin
      step_in   = step_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      mon_in    = mon_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      req_ready = 1'b0;

      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_second_in = rsp_second_ff;
      rsp_minute_in = rsp_minute_ff;
      rsp_hour_in   = rsp_hour_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_year_in   = rsp_year_ff;

      case (cw.op)
         es2c_pkg::OP_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rem_in  = req_epoch_seconds;
               q_in    = '0;
               year_in = es2c_pkg::FIRST_YEAR;
               mon_in  = '0;
               step_in = cw.next;
            end
         end
         es2c_pkg::OP_QUO: begin
            q_in    = quo;
            step_in = cw.next;
         end
         es2c_pkg::OP_REM: begin
            rem_in = rem_ff - back;
            case (cw.dst)
               es2c_pkg::DST_DAYS: days_in   = q_ff;
               es2c_pkg::DST_HOUR: hour_in   = q_ff[4:0];
               es2c_pkg::DST_MIN:  minute_in = q_ff[5:0];
               default: ;
            endcase
            step_in = cw.next;
         end
         es2c_pkg::OP_YEAR: begin
            if (days_ff >= {{(es2c_pkg::DAYS_W-9){1'b0}}, ylen}) begin
               days_in = days_ff - {{(es2c_pkg::DAYS_W-9){1'b0}}, ylen};
               year_in = year_ff + 8'd1;
            end else begin
               step_in = cw.next;
            end
         end
         es2c_pkg::OP_MONTH: begin
            if ((days_ff < {{(es2c_pkg::DAYS_W-5){1'b0}}, mlen}) ||
                (mon_ff == es2c_pkg::LAST_MONTH)) begin
               step_in = cw.next;
            end else begin
               days_in = days_ff - {{(es2c_pkg::DAYS_W-5){1'b0}}, mlen};
               mon_in  = mon_ff + 4'd1;
            end
         end
         es2c_pkg::OP_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_second_in = rem_ff[5:0];
               rsp_minute_in = minute_ff;
               rsp_hour_in   = hour_ff;
               rsp_day_in    = days_ff[4:0] + 5'd1;
               rsp_month_in  = mon_ff + 4'd1;
               rsp_year_in   = year_ff;
               step_in       = cw.next;
            end
         end
         default: begin
            step_in = es2c_pkg::STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= es2c_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      days_ff       <= days_in;
      year_ff       <= year_in;
      mon_ff        <= mon_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      rsp_second_ff <= rsp_second_in;
      rsp_minute_ff <= rsp_minute_in;
      rsp_hour_ff   <= rsp_hour_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_year_ff   <= rsp_year_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_second          = rsp_second_ff;
   assign rsp_minute          = rsp_minute_ff;
   assign rsp_hour            = rsp_hour_ff;
   assign rsp_day_of_month    = rsp_day_ff;
   assign rsp_month           = rsp_month_ff;
   assign rsp_year_since_1900 = rsp_year_ff;

endmodule

// ----- hdl/es2c_checker.sv -----
// ----------------------------------------------------------------------------
// es2c_checker
// Port-level checks for epoch_seconds_to_calendar, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module es2c_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_second,
   input logic [5:0]  rsp_minute,
   input logic [4:0]  rsp_hour,
   input logic [4:0]  rsp_day_of_month,
   input logic [3:0]  rsp_month,
   input logic [7:0]  rsp_year_since_1900
);

   `ASSERT_NEXT(rsp_cleared_by_reset, clock, 1'b0, reset, !rsp_valid)
   `ASSERT_NEXT(busy_after_request, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_ALWAYS(fields_in_range, clock, reset, !rsp_valid || (rsp_second < 6'd60 && rsp_minute < 6'd60 && rsp_hour < 5'd24 && rsp_day_of_month != 5'd0 && rsp_month != 4'd0 && rsp_month <= 4'd12 && rsp_year_since_1900 >= 8'd70 && rsp_year_since_1900 <= 8'd206))
   `ASSERT_NEXT(rsp_held_while_stalled, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_second) && $stable(rsp_minute) && $stable(rsp_hour) && $stable(rsp_day_of_month) && $stable(rsp_month) && $stable(rsp_year_since_1900))

endmodule

bind epoch_seconds_to_calendar es2c_checker u_es2c_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_second          (rsp_second),
   .rsp_minute          (rsp_minute),
   .rsp_hour            (rsp_hour),
   .rsp_day_of_month    (rsp_day_of_month),
   .rsp_month           (rsp_month),
   .rsp_year_since_1900 (rsp_year_since_1900)
);

// ----- tb/epoch_seconds_to_calendar_test.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_test
// Sends epoch second counts into the converter and checks every calendar
// result against an in-bench model. Covers directed boundary dates,
// random counts and calendar-shaped counts, under several idle and stall
// mixes, plus one long output hold-off.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_test;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      bit [5:0] second;
      bit [5:0] minute;
      bit [4:0] hour;
      bit [4:0] day_of_month;
      bit [3:0] month;
      bit [7:0] year_since_1900;
   } calendar_type;

   class calendar_scoreboard;
      calendar_type pending[$];
      int unsigned mismatches = 0;

      static function int unsigned month_length(int unsigned year, int unsigned mon0);
         int unsigned len;
         case (mon0)
            0, 2, 4, 6, 7, 9, 11: len = 31;
            3, 5, 8, 10:          len = 30;
            default:              len = (year % 4 == 0) ? 29 : 28;
         endcase
         return len;
      endfunction

      static function int unsigned year_length(int unsigned year);
         return (year % 4 == 0) ? 366 : 365;
      endfunction

      // simple leap rule: every fourth year, 2100 included
      function calendar_type to_calendar(bit [31:0] secs);
         int unsigned days;
         int unsigned hms;
         int unsigned year;
         int unsigned mon0;
         calendar_type c;
         days = secs / 86400;
         hms  = secs % 86400;
         year = 70;
         mon0 = 0;
         while (days >= year_length(year)) begin
            days -= year_length(year);
            year++;
         end
         while (mon0 < 11 && days >= month_length(year, mon0)) begin
            days -= month_length(year, mon0);
            mon0++;
         end
         c.second          = 6'((hms % 3600) % 60);
         c.minute          = 6'((hms % 3600) / 60);
         c.hour            = 5'(hms / 3600);
         c.day_of_month    = 5'(days + 1);
         c.month           = 4'(mon0 + 1);
         c.year_since_1900 = 8'(year);
         return c;
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         mismatches++;
      endtask

      function void note_request(bit [31:0] secs);
         pending.push_back(to_calendar(secs));
      endfunction

      task compare_field(string name, int unsigned got, int unsigned want);
         if (got != want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_result(calendar_type got);
         calendar_type want;
         if (pending.size() == 0) begin
            report("result with no request pending");
         end else begin
            want = pending.pop_front();
            compare_field("second", got.second, want.second);
            compare_field("minute", got.minute, want.minute);
            compare_field("hour", got.hour, want.hour);
            compare_field("day_of_month", got.day_of_month, want.day_of_month);
            compare_field("month", got.month, want.month);
            compare_field("year_since_1900", got.year_since_1900, want.year_since_1900);
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_epoch_seconds;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [5:0]  rsp_second;
   logic [5:0]  rsp_minute;
   logic [4:0]  rsp_hour;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month;
   logic [7:0]  rsp_year_since_1900;

   calendar_scoreboard board = new();

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   bit          pressure_phase = 1'b0;

   epoch_seconds_to_calendar uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_epoch_seconds   (req_epoch_seconds),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_second          (rsp_second),
      .rsp_minute          (rsp_minute),
      .rsp_hour            (rsp_hour),
      .rsp_day_of_month    (rsp_day_of_month),
      .rsp_month           (rsp_month),
      .rsp_year_since_1900 (rsp_year_since_1900)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

   // year is years since 1900, month 1..12, day 1..31
   function longint unsigned epoch_of(int unsigned year, int unsigned month,
                                      int unsigned day, int unsigned hh,
                                      int unsigned mm, int unsigned ss);
      longint unsigned days;
      days = 0;
      for (int unsigned y = 70; y < year; y++)
         days += calendar_scoreboard::year_length(y);
      for (int unsigned m = 0; m + 1 < month; m++)
         days += calendar_scoreboard::month_length(year, m);
      days += day - 1;
      return days * 86400 + hh * 3600 + mm * 60 + ss;
   endfunction

   // mostly calendar dates, often on a month's first or last day, the rest raw 32-bit counts
   function bit [31:0] pick_epoch();
      int unsigned year;
      int unsigned month;
      int unsigned day;
      int unsigned last;
      longint unsigned secs;
      if ($urandom_range(99) < 40)
         return $urandom;
      year  = $urandom_range(206, 70);
      month = $urandom_range(12, 1);
      last  = calendar_scoreboard::month_length(year, month - 1);
      case ($urandom_range(2))
         0:       day = 1;
         1:       day = last;
         default: day = $urandom_range(last, 1);
      endcase
      case ($urandom_range(2))
         0:       secs = epoch_of(year, month, day, 0, 0, 0);
         1:       secs = epoch_of(year, month, day, 23, 59, 59);
         default: secs = epoch_of(year, month, day, $urandom_range(23),
                                  $urandom_range(59), $urandom_range(59));
      endcase
      if (secs > 64'hFFFF_FFFF)
         return $urandom;
      return secs[31:0];
   endfunction

   task send_request(bit [31:0] secs);
      int unsigned gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (!req_ready);
      board.note_request(secs);
   endtask

   task run_random(int unsigned count, int unsigned idle_pct, int unsigned stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_request(pick_epoch());
   endtask

   // response side; a rise of pressure_phase starts a long hold-off
   initial begin
      int unsigned hold_left;
      bit          pressure_seen;
      hold_left     = 0;
      pressure_seen = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_result({rsp_second, rsp_minute, rsp_hour, rsp_day_of_month,
                                rsp_month, rsp_year_since_1900});
         if (pressure_phase && !pressure_seen)
            hold_left = 300;
         pressure_seen = pressure_phase;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      bit [31:0] directed[$];
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_epoch_seconds <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      directed = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
                   32'd86399, 32'd86400,
                   32'(epoch_of(70, 12, 31, 23, 59, 59)),
                   32'(epoch_of(72, 2, 29, 12, 0, 0)),
                   32'(epoch_of(72, 3, 1, 0, 0, 0)),
                   32'(epoch_of(73, 2, 28, 23, 59, 59)),
                   32'(epoch_of(73, 3, 1, 0, 0, 0)),
                   32'(epoch_of(200, 2, 29, 6, 30, 15)),   // 2100 counts as leap
                   32'(epoch_of(200, 12, 31, 23, 59, 59)),
                   32'(epoch_of(201, 1, 1, 0, 0, 0)),
                   32'(epoch_of(206, 1, 1, 0, 0, 0)),
                   32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
      foreach (directed[i])
         send_request(directed[i]);

      run_random(500, 0, 0);

      // hold off the output while requests keep coming
      pressure_phase = 1'b1;
      run_random(20, 0, 0);
      pressure_phase = 1'b0;

      run_random(500, 60, 0);
      run_random(500, 0, 60);
      run_random(500, 28, 28);
      req_valid <= 1'b0;

      while (board.pending.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.pending.size() != 0)
         board.report("expected results left over");

      if (board.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
